@@ hw/rtl/box_iou_unit_defines.svh @@
// Assertion macros used by the checker of the box IoU unit.
`ifndef BOX_IOU_UNIT_DEFINES_SVH
`define BOX_IOU_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BIOU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BIOU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/biou_pkg.sv @@
`timescale 1ns / 1ps

package biou_pkg;

  typedef struct packed {
    logic valid;
    logic overlap;
  } biou_ctl_t;

endpackage

@@ hw/rtl/biou_if.sv @@
`timescale 1ns / 1ps

interface biou_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_x;
  logic signed [COORD_BITS-1:0] a_y;
  logic        [COORD_BITS-2:0] a_width;
  logic        [COORD_BITS-2:0] a_height;
  logic signed [COORD_BITS-1:0] b_x;
  logic signed [COORD_BITS-1:0] b_y;
  logic        [COORD_BITS-2:0] b_width;
  logic        [COORD_BITS-2:0] b_height;

  modport source (
    output valid, a_x, a_y, a_width, a_height, b_x, b_y, b_width, b_height,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, a_width, a_height, b_x, b_y, b_width, b_height,
    output ready
  );
endinterface

interface biou_out_if #(
  parameter int FRAC_BITS = 16
);
  logic               valid;
  logic               ready;
  logic [FRAC_BITS:0] iou;
  logic               overlapping;

  modport source (
    output valid, iou, overlapping,
    input  ready
  );
  modport sink (
    input  valid, iou, overlapping,
    output ready
  );
endinterface

@@ hw/rtl/biou_front.sv @@
`timescale 1ns / 1ps

module biou_front import biou_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  biou_in_if.sink                   in_box,
  output biou_ctl_t                 ctl_o,
  output logic [2*COORD_BITS-1:0]   inter_o,
  output logic [2*COORD_BITS-1:0]   uni_o,
  input  logic                      ready_i
);

  localparam int C = COORD_BITS;
  localparam int P = 2 * COORD_BITS;
  localparam logic [C-1:0]   ONE_C = C'(1);
  localparam logic [C+1:0]   ONE_D = (C + 2)'(1);

  logic ready1, ready2, ready3, ready4;
  logic v1_r, v2_r, v3_r, v4_r;

  // Stage 1: edges and inclusive sizes.
  logic signed [C-1:0] left_nxt, top_nxt, left_r, top_r;
  logic signed [C:0]   ra, rb, ba, bb, right_nxt, bottom_nxt, right_r, bottom_r;
  logic [C-1:0]        wa_nxt, ha_nxt, wb_nxt, hb_nxt;
  logic [C-1:0]        wa_r, ha_r, wb_r, hb_r;

  // Stage 2: intersection extents.
  logic signed [C+1:0] dx, dy, dxp1, dyp1;
  logic                ov_nxt, ov2_r;
  logic [C-1:0]        iw_nxt, ih_nxt, iw_r, ih_r;
  logic [C-1:0]        wa2_r, ha2_r, wb2_r, hb2_r;

  // Stage 3: products.
  logic [P-1:0]        inter_nxt, area_a_nxt, area_b_nxt;
  logic [P-1:0]        inter3_r, area_a_r, area_b_r;
  logic                ov3_r;

  // Stage 4: union.
  logic [P-1:0]        uni_nxt, uni_r, inter4_r;
  logic                ov4_r;

  always_comb begin
    ready4 = !v4_r || ready_i;
    ready3 = !v3_r || ready4;
    ready2 = !v2_r || ready3;
    ready1 = !v1_r || ready2;
  end

  assign in_box.ready = ready1;

  always_comb begin
    ra = $signed({in_box.a_x[C-1], in_box.a_x}) + $signed({2'b00, in_box.a_width});
    rb = $signed({in_box.b_x[C-1], in_box.b_x}) + $signed({2'b00, in_box.b_width});
    ba = $signed({in_box.a_y[C-1], in_box.a_y}) + $signed({2'b00, in_box.a_height});
    bb = $signed({in_box.b_y[C-1], in_box.b_y}) + $signed({2'b00, in_box.b_height});
    left_nxt   = (in_box.a_x > in_box.b_x) ? in_box.a_x : in_box.b_x;
    top_nxt    = (in_box.a_y > in_box.b_y) ? in_box.a_y : in_box.b_y;
    right_nxt  = (ra < rb) ? ra : rb;
    bottom_nxt = (ba < bb) ? ba : bb;
    wa_nxt = {1'b0, in_box.a_width} + ONE_C;
    ha_nxt = {1'b0, in_box.a_height} + ONE_C;
    wb_nxt = {1'b0, in_box.b_width} + ONE_C;
    hb_nxt = {1'b0, in_box.b_height} + ONE_C;
  end

  always_comb begin
    dx   = $signed({right_r[C], right_r}) - $signed({{2{left_r[C-1]}}, left_r});
    dy   = $signed({bottom_r[C], bottom_r}) - $signed({{2{top_r[C-1]}}, top_r});
    dxp1 = dx + $signed(ONE_D);
    dyp1 = dy + $signed(ONE_D);
    ov_nxt = !dx[C+1] && !dy[C+1];
    iw_nxt = ov_nxt ? dxp1[C-1:0] : '0;
    ih_nxt = ov_nxt ? dyp1[C-1:0] : '0;
  end

  always_comb begin
    inter_nxt  = P'(iw_r) * P'(ih_r);
    area_a_nxt = P'(wa2_r) * P'(ha2_r);
    area_b_nxt = P'(wb2_r) * P'(hb2_r);
    uni_nxt    = area_a_r + area_b_r - inter3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (ready1) v1_r <= in_box.valid;
      if (ready2) v2_r <= v1_r;
      if (ready3) v3_r <= v2_r;
      if (ready4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_box.valid) begin
      left_r   <= left_nxt;
      top_r    <= top_nxt;
      right_r  <= right_nxt;
      bottom_r <= bottom_nxt;
      wa_r     <= wa_nxt;
      ha_r     <= ha_nxt;
      wb_r     <= wb_nxt;
      hb_r     <= hb_nxt;
    end
    if (ready2 && v1_r) begin
      ov2_r <= ov_nxt;
      iw_r  <= iw_nxt;
      ih_r  <= ih_nxt;
      wa2_r <= wa_r;
      ha2_r <= ha_r;
      wb2_r <= wb_r;
      hb2_r <= hb_r;
    end
    if (ready3 && v2_r) begin
      ov3_r    <= ov2_r;
      inter3_r <= inter_nxt;
      area_a_r <= area_a_nxt;
      area_b_r <= area_b_nxt;
    end
    if (ready4 && v3_r) begin
      ov4_r    <= ov3_r;
      inter4_r <= inter3_r;
      uni_r    <= uni_nxt;
    end
  end

  assign ctl_o   = '{valid: v4_r, overlap: ov4_r};
  assign inter_o = inter4_r;
  assign uni_o   = uni_r;

endmodule

@@ hw/rtl/biou_div_cell.sv @@
`timescale 1ns / 1ps

module biou_div_cell import biou_pkg::*; #(
  parameter int REM_BITS  = 33,
  parameter int QUOT_BITS = 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  biou_ctl_t            ctl_i,
  input  logic [REM_BITS-1:0]  rem_i,
  input  logic [REM_BITS-2:0]  div_i,
  input  logic [QUOT_BITS-1:0] quot_i,
  output logic                 ready_o,
  output biou_ctl_t            ctl_o,
  output logic [REM_BITS-1:0]  rem_o,
  output logic [REM_BITS-2:0]  div_o,
  output logic [QUOT_BITS-1:0] quot_o,
  input  logic                 ready_i
);

  biou_ctl_t             ctl_r;
  logic [REM_BITS-1:0]   rem_r, rem_nxt, rem_sub;
  logic [REM_BITS-2:0]   div_r;
  logic [QUOT_BITS-1:0]  quot_r, quot_nxt;
  logic                  ge;

  // One restoring step: take one quotient bit, then shift the remainder on.
  always_comb begin
    ge       = rem_i >= {1'b0, div_i};
    rem_sub  = ge ? (rem_i - {1'b0, div_i}) : rem_i;
    rem_nxt  = {rem_sub[REM_BITS-2:0], 1'b0};
    quot_nxt = {quot_i[QUOT_BITS-2:0], ge};
  end

  assign ready_o = !ctl_r.valid || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (ready_o) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && ctl_i.valid) begin
      rem_r  <= rem_nxt;
      div_r  <= div_i;
      quot_r <= quot_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign rem_o  = rem_r;
  assign div_o  = div_r;
  assign quot_o = quot_r;

endmodule

@@ hw/rtl/box_iou_unit.sv @@
`timescale 1ns / 1ps

// Box IoU unit: takes one pair of axis-aligned boxes per transfer and returns
// their intersection over union as unsigned Q.FRAC_BITS, truncated, together
// with an overlap flag; disjoint boxes give zero with the flag cleared. Edges
// and areas use the inclusive convention, so a box covers (width + 1) by
// (height + 1) pixels. The block accepts a new pair every cycle unless a stalled
// result backs up to the input, and holds no state between pairs. The pipeline
// has four front stages (edges, extents, area multipliers, union) followed by a
// chain of FRAC_BITS + 1 divider cells, each producing one quotient bit.
// A stalled result only holds back the cells behind it that are already full.
module box_iou_unit import biou_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  biou_in_if.sink     in_box,
  biou_out_if.source  out_res
);

  localparam int P = 2 * COORD_BITS;
  localparam int R = P + 1;
  localparam int N = FRAC_BITS + 1;

  biou_ctl_t              ctl  [N+1];
  logic [R-1:0]           rem  [N+1];
  logic [P-1:0]           div  [N+1];
  logic [FRAC_BITS:0]     quot [N+1];
  logic [N:0]             rdy;
  logic [P-1:0]           inter;

  biou_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_box  (in_box),
    .ctl_o   (ctl[0]),
    .inter_o (inter),
    .uni_o   (div[0]),
    .ready_i (rdy[0])
  );

  assign rem[0]  = {1'b0, inter};
  assign quot[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_cell
    biou_div_cell #(
      .REM_BITS  (R),
      .QUOT_BITS (N)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl[k]),
      .rem_i   (rem[k]),
      .div_i   (div[k]),
      .quot_i  (quot[k]),
      .ready_o (rdy[k]),
      .ctl_o   (ctl[k+1]),
      .rem_o   (rem[k+1]),
      .div_o   (div[k+1]),
      .quot_o  (quot[k+1]),
      .ready_i (rdy[k+1])
    );
  end

  assign rdy[N]              = out_res.ready;
  assign out_res.valid       = ctl[N].valid;
  assign out_res.iou         = quot[N];
  assign out_res.overlapping = ctl[N].overlap;

endmodule

@@ hw/rtl/biou_checker.sv @@
`timescale 1ns / 1ps
`include "box_iou_unit_defines.svh"

module biou_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FRAC_BITS:0] out_iou,
  input logic               out_overlapping
);

  `BIOU_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_iou) && $stable(out_overlapping), "Stalled result changed.")
  `BIOU_ASSERT_IMP(a_disjoint_zero, clk, rst_n, out_valid && !out_overlapping, out_iou == '0, "Disjoint boxes gave a nonzero IoU.")
  `BIOU_ASSERT_IMP(a_iou_max, clk, rst_n, out_valid && out_iou[FRAC_BITS], out_iou[FRAC_BITS-1:0] == '0, "IoU exceeds one.")
  `BIOU_ASSERT_IMP(a_empty_ready, clk, rst_n, !out_valid, in_ready, "Input not ready while the result side is empty.")

endmodule

bind box_iou_unit biou_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_biou_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_box.ready),
  .out_valid       (out_res.valid),
  .out_ready       (out_res.ready),
  .out_iou         (out_res.iou),
  .out_overlapping (out_res.overlapping)
);
